[sv/pcbp_pkg.sv]
// Shared types and constants for the prefix code bit packer.
`timescale 1ns / 1ps

package pcbp_pkg;

	// Request kinds carried in the input tuser field.
	typedef enum logic [1:0] {
		REQ_WRITE  = 2'd0,
		REQ_ENCODE = 2'd1,
		REQ_FLUSH  = 2'd2
	} req_type_t;

	// Fixed field widths of the stream ports.
	localparam int SYMBOL_W   = 8;
	localparam int CODE_IN_W  = 64;
	localparam int LEN_W      = 7;
	localparam int IN_TDATA_W = 80;
	localparam int PART_W     = 7;
	localparam int POS_W      = 3;

endpackage

[sv/prefix_code_bit_packer_unit.sv]
// Top level of the prefix code bit packer: table, input stage, packer and byte drain.
`timescale 1ns / 1ps

// A write transaction loads one table entry, an encode transaction appends the
// symbol's code to the bit packer and a flush transaction pads the open byte with
// ones. Every transaction passes one input register, where the table read completes,
// and is merged with the packer combinationally. A new transaction is taken every
// cycle while each yields at most one byte and the output takes it; one that yields
// k bytes (up to eight for a 64-bit code) holds the output drain register, one byte
// per cycle while m_tready is high, and the input waits behind it. Writes take effect
// for an encode in the very next cycle. The table needs no clearing after reset.

module prefix_code_bit_packer_unit
	import pcbp_pkg::*;
#(
	parameter int SYMBOL_COUNT  = 256,
	parameter int MAX_CODE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// symbol [7:0], code_bits [71:8], code_length [78:72], zero [79]
	input  logic [IN_TDATA_W-1:0] s_tdata,
	// req_type [1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_byte [7:0]
	output logic [7:0]            m_tdata,
	output logic                  m_tlast,
	// end_of_stream [0]
	output logic [0:0]            m_tuser
);

	localparam int IDX_W     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int MAX_BYTES = (MAX_CODE_BITS + PART_W) / 8;
	localparam int BUF_W     = 8 * MAX_BYTES + 8;
	localparam int NB_W      = $clog2(MAX_BYTES + 1);

	// Input field split.
	logic [SYMBOL_W-1:0]  in_symbol;
	logic [CODE_IN_W-1:0] in_code_bits;
	logic [LEN_W-1:0]     in_code_length;
	req_type_t            in_req;
	logic                 in_range;
	logic                 s_acc;

	assign in_symbol      = s_tdata[SYMBOL_W-1:0];
	assign in_code_bits   = s_tdata[SYMBOL_W+CODE_IN_W-1:SYMBOL_W];
	assign in_code_length = s_tdata[SYMBOL_W+CODE_IN_W+LEN_W-1:SYMBOL_W+CODE_IN_W];
	assign in_req         = req_type_t'(s_tuser);
	assign in_range       = ({1'b0, in_symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT));
	assign s_acc          = s_tvalid & s_tready;

	// Table read results arrive with the input stage.
	logic [MAX_CODE_BITS-1:0] rd_code;
	logic [LEN_W-1:0]         rd_len;

	pcbp_code_table #(
		.SYMBOL_COUNT  (SYMBOL_COUNT),
		.MAX_CODE_BITS (MAX_CODE_BITS),
		.IDX_W         (IDX_W)
	) u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (s_acc && (in_req == REQ_WRITE) && in_range),
		.wr_idx       (in_symbol[IDX_W-1:0]),
		.wr_code_bits (in_code_bits),
		.wr_len       (in_code_length),
		.rd_en        (s_acc),
		.rd_idx       (in_symbol[IDX_W-1:0]),
		.rd_code      (rd_code),
		.rd_len       (rd_len)
	);

	// Input stage registers.
	logic      valid_s1;
	req_type_t req_s1;
	logic      in_range_s1;

	// Packer state and output drain.
	logic [PART_W-1:0] part_q;
	logic [POS_W-1:0]  pos_q;
	logic [BUF_W-1:0]  drain_q;
	logic [NB_W-1:0]   cnt_q;
	logic              eos_q;

	// Merge results.
	logic [LEN_W-1:0]         n_c;
	logic [MAX_CODE_BITS-1:0] code_c;
	logic [7:0]               total_c;
	logic [BUF_W-1:0]         buf_c;
	logic [NB_W-1:0]          nb_c;
	logic [PART_W-1:0]        part_c;
	logic [POS_W-1:0]         pos_c;
	logic [7:0]               pad_byte;

	// Merge the pending item with the open byte of the packer.
	always_comb begin
		n_c      = in_range_s1 ? rd_len : '0;
		code_c   = (n_c == '0) ? '0 : rd_code;
		total_c  = 8'(pos_q) + 8'(n_c);
		pad_byte = {part_q, 1'b0} | (8'hFF >> pos_q);
		buf_c    = '0;
		nb_c     = '0;
		part_c   = part_q;
		pos_c    = pos_q;
		unique case (req_s1)
			REQ_ENCODE: begin
				buf_c = {part_q, {(BUF_W-PART_W){1'b0}}}
					| ({code_c, {(BUF_W-MAX_CODE_BITS){1'b0}}} >> pos_q);
				nb_c  = NB_W'(total_c[7:3]);
				pos_c = total_c[2:0];
				for (int k = 0; k <= MAX_BYTES; k++) begin
					if (nb_c == NB_W'(k)) begin
						part_c = buf_c[BUF_W-1-8*k -: PART_W];
					end
				end
			end
			REQ_FLUSH: begin
				if (pos_q != '0) begin
					buf_c  = {pad_byte, {(BUF_W-8){1'b0}}};
					nb_c   = NB_W'(1);
					part_c = '0;
					pos_c  = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Handshake: the input stage moves on once the drain can take its bytes.
	logic m_acc;
	logic drain_free;
	logic adv_s1;

	assign m_acc      = m_tvalid & m_tready;
	assign drain_free = (cnt_q == '0) || ((cnt_q == NB_W'(1)) && m_acc);
	assign adv_s1     = valid_s1 && ((nb_c == '0) || drain_free);
	assign s_tready   = !valid_s1 || adv_s1;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			req_s1      <= in_req;
			in_range_s1 <= in_range;
		end
	end

	// Packer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			pos_q  <= '0;
		end else if (adv_s1) begin
			part_q <= part_c;
			pos_q  <= pos_c;
		end
	end

	// Output drain: the bytes of one transaction, earliest byte at the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			eos_q <= 1'b0;
		end else if (adv_s1 && (nb_c != '0)) begin
			cnt_q <= nb_c;
			eos_q <= (req_s1 == REQ_FLUSH);
		end else if (m_acc) begin
			cnt_q <= cnt_q - NB_W'(1);
			if (cnt_q == NB_W'(1)) begin
				eos_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && (nb_c != '0)) begin
			drain_q <= buf_c;
		end else if (m_acc) begin
			drain_q <= {drain_q[BUF_W-9:0], 8'h00};
		end
	end

	assign m_tvalid   = (cnt_q != '0);
	assign m_tdata    = drain_q[BUF_W-1 -: 8];
	assign m_tlast    = (cnt_q == NB_W'(1));
	assign m_tuser[0] = eos_q;

endmodule

[sv/pcbp_code_table.sv]
// Code table: per-symbol left-aligned code and length with registered read.
`timescale 1ns / 1ps

module pcbp_code_table
	import pcbp_pkg::*;
#(
	parameter int SYMBOL_COUNT  = 256,
	parameter int MAX_CODE_BITS = 64,
	parameter int IDX_W         = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [IDX_W-1:0]         wr_idx,
	input  logic [CODE_IN_W-1:0]     wr_code_bits,
	input  logic [LEN_W-1:0]         wr_len,
	input  logic                     rd_en,
	input  logic [IDX_W-1:0]         rd_idx,
	output logic [MAX_CODE_BITS-1:0] rd_code,
	output logic [LEN_W-1:0]         rd_len
);

	logic [MAX_CODE_BITS-1:0] code_mem [SYMBOL_COUNT];
	logic [LEN_W-1:0]         len_mem  [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0]  entry_valid_q;

	logic [LEN_W-1:0]         len_clamped;
	logic [MAX_CODE_BITS-1:0] len_mask;
	logic [LEN_W-1:0]         align_shift;
	logic [MAX_CODE_BITS-1:0] code_aligned;

	// Clamp the length, drop bits above it and move the first bit to the top.
	always_comb begin
		if (wr_len > LEN_W'(MAX_CODE_BITS)) begin
			len_clamped = LEN_W'(MAX_CODE_BITS);
		end else begin
			len_clamped = wr_len;
		end
		for (int i = 0; i < MAX_CODE_BITS; i++) begin
			len_mask[i] = (i < int'(len_clamped));
		end
		align_shift  = LEN_W'(MAX_CODE_BITS) - len_clamped;
		code_aligned = (wr_code_bits[MAX_CODE_BITS-1:0] & len_mask) << align_shift;
	end

	// Table storage; the code array has no reset.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			code_mem[wr_idx] <= code_aligned;
			len_mem[wr_idx]  <= len_clamped;
		end
	end

	// Valid bits stand in for the all-zero reset of the length array.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (wr_en) begin
			entry_valid_q[wr_idx] <= 1'b1;
		end
	end

	// Registered read; an entry never written reads as length zero.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_code <= code_mem[rd_idx];
			rd_len  <= entry_valid_q[rd_idx] ? len_mem[rd_idx] : '0;
		end
	end

endmodule

[sv/pcbp_checker.sv]
// Port-level checks for the prefix code bit packer, bound to the top level.
`timescale 1ns / 1ps

module pcbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic [0:0]  m_tuser
);

	// The padded flush byte is always the last byte of its transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("end of stream without last of run");

	// Padding always leaves at least one trailing one bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[0])
		else $error("padded byte does not end in a one");

	// With nothing in the drain the input side never stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output");

	// A stalled output byte holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output changed while stalled");

endmodule

bind prefix_code_bit_packer_unit pcbp_checker u_pcbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

[tb/sv/tb_top.sv]
// Self-checking stream testbench for the prefix code bit packer top level.
`timescale 1ns / 1ps

module tb_top;
	import pcbp_pkg::*;

	localparam int TBL_SIZE      = 256;
	localparam int CODE_MAX      = 64;
	localparam int RAND_ITEMS    = 296;
	localparam int DRAIN_CYCLES  = 20;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int HOLD_CYCLES   = 400;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	// One request as the sender offers it, with the idle time that follows it.
	typedef struct {
		logic [1:0]          req;
		logic [SYMBOL_W-1:0] sym;
		logic [63:0]         bits;
		logic [LEN_W-1:0]    len;
		int                  gap;
	} packer_req_t;

	// One byte expected on the output stream.
	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       eos;
	} coded_byte_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// symbol [7:0], code_bits [71:8], code_length [78:72], zero [79]
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	// req_type [1:0]
	logic [1:0]            s_tuser = 2'd0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// out_byte [7:0]
	logic [7:0]            m_tdata;
	logic                  m_tlast;
	// end_of_stream [0]
	logic [0:0]            m_tuser;

	packer_req_t req_backlog[$];
	coded_byte_t coded_bytes_due[$];

	// Shadow copy of the code table and the bit packer.
	logic [63:0]      code_tab[TBL_SIZE];
	logic [LEN_W-1:0] len_tab[TBL_SIZE];
	logic [PART_W-1:0] pk_part = '0;
	logic [POS_W-1:0]  pk_pos = '0;
	logic [7:0]       run_buf[8];
	int               run_n;

	int  in_sent = 0;
	int  in_accepted = 0;
	int  in_gap = 0;
	int  out_accepted = 0;
	int  out_seen = 0;
	int  rx_wait = 0;
	int  rx_hold = 0;
	bit  hold_done = 1'b0;
	int  fails = 0;
	int  cycles = 0;
	bit  tx_calm = 1'b0;

	prefix_code_bit_packer_unit #(
		.SYMBOL_COUNT (TBL_SIZE),
		.MAX_CODE_BITS(CODE_MAX)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	// Free-running clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Shift one bit into the shadow packer and collect a byte when it completes.
	task automatic shift_in(input logic b);
		logic [7:0] acc;
		acc = {pk_part, b};
		if (pk_pos == 3'd7) begin
			run_buf[run_n] = acc;
			run_n++;
			pk_part = '0;
			pk_pos = '0;
		end else begin
			pk_part = acc[6:0];
			pk_pos = pk_pos + 3'd1;
		end
	endtask

	// Apply one accepted request to the shadow state and queue the bytes it yields.
	task automatic encode_item(input logic [1:0] req, input logic [7:0] sym,
			input logic [63:0] bits, input logic [6:0] len);
		int          n;
		int          i;
		logic [63:0] code;
		coded_byte_t cb;
		run_n = 0;
		if (req == REQ_WRITE) begin
			if (sym < TBL_SIZE) begin
				n = (len > CODE_MAX) ? CODE_MAX : len;
				code = (n < 64) ? (bits & ((64'd1 << n) - 64'd1)) : bits;
				code_tab[sym] = code;
				len_tab[sym] = n[6:0];
			end
		end else if (req == REQ_ENCODE) begin
			if (sym < TBL_SIZE) begin
				n = (len_tab[sym] > CODE_MAX) ? CODE_MAX : len_tab[sym];
				for (i = n; i > 0; i--)
					shift_in(code_tab[sym][i-1]);
			end
		end else if (req == REQ_FLUSH) begin
			while (pk_pos != 0)
				shift_in(1'b1);
		end
		for (i = 0; i < run_n; i++) begin
			cb.data = run_buf[i];
			cb.last = (i == run_n - 1);
			cb.eos = (i == run_n - 1) && (req == REQ_FLUSH);
			coded_bytes_due = {coded_bytes_due, cb};
		end
	endtask

	// Input side: predict on every accepted transaction.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			encode_item(s_tuser, s_tdata[7:0], s_tdata[71:8], s_tdata[78:72]);
			in_accepted++;
		end
	end

	// Driver: offer the next pending request once the previous one is taken.
	always @(negedge clk) begin
		packer_req_t it;
		if (arst_n && !(s_tvalid && in_accepted < in_sent)) begin
			if (in_gap > 0) begin
				in_gap--;
				s_tvalid <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				it = req_backlog.pop_front();
				s_tdata <= {1'b0, it.len, it.bits, it.sym};
				s_tuser <= it.req;
				s_tvalid <= 1'b1;
				in_gap = it.gap;
				in_sent++;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: compare each output transaction with the oldest expected byte.
	always @(posedge clk) begin
		coded_byte_t e;
		if (arst_n && m_tvalid && m_tready) begin
			out_accepted++;
			if (coded_bytes_due.size() == 0) begin
				$error("unexpected output byte %h", m_tdata);
				fails++;
			end else begin
				e = coded_bytes_due.pop_front();
				if (m_tdata !== e.data) begin
					$error("out_byte: expected %h, actual %h", e.data, m_tdata);
					fails++;
				end
				if (m_tlast !== e.last) begin
					$error("last_of_run: expected %b, actual %b", e.last, m_tlast);
					fails++;
				end
				if (m_tuser[0] !== e.eos) begin
					$error("end_of_stream: expected %b, actual %b", e.eos, m_tuser[0]);
					fails++;
				end
			end
		end
	end

	// Receiver: random stall after each byte, calm stretches and one long hold-off.
	always @(negedge clk) begin
		if (out_seen != out_accepted) begin
			out_seen = out_accepted;
			rx_wait = ((out_accepted / 60) % 4 == 3) ? 0 : $urandom_range(0, 4);
		end
		if (!hold_done && out_accepted >= 40) begin
			hold_done = 1'b1;
			rx_hold = HOLD_CYCLES;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** prefix_code_bit_packer_unit: FAILED **");
			$finish;
		end
	end

	// Queue one request with an idle gap drawn for the sender.
	task automatic add_req(input logic [1:0] req, input logic [7:0] sym,
			input logic [63:0] bits, input logic [6:0] len);
		packer_req_t it;
		it.req = req;
		it.sym = sym;
		it.bits = bits;
		it.len = len;
		it.gap = tx_calm ? 0 : $urandom_range(0, 4);
		req_backlog = {req_backlog, it};
	endtask

	// Stimulus, reset and end of run.
	initial begin
		bit          written[TBL_SIZE];
		logic [7:0]  wr_list[$];
		logic [7:0]  sym;
		logic [63:0] bits;
		logic [6:0]  len;
		int          k;
		int          pick;
		int          lsel;

		arst_n = 1'b0;
		foreach (written[i]) begin
			written[i] = 1'b0;
			len_tab[i] = '0;
		end

		// Directed: table extremes, clamping, removal and each flush corner.
		add_req(REQ_FLUSH, 8'h00, 64'h0, 7'd0);
		add_req(REQ_WRITE, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1);
		add_req(REQ_WRITE, 8'd255, 64'hA5C3_0F96_5A3C_F069, 7'd64);
		add_req(REQ_WRITE, 8'd1, 64'h0123_4567_89AB_CDEF, 7'd100);
		add_req(REQ_WRITE, 8'd2, 64'hFFFF_FFFF_FFFF_FF00, 7'd7);
		add_req(REQ_WRITE, 8'd3, 64'h5555_5555_5555_5555, 7'd0);
		add_req(REQ_WRITE, 8'd4, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
		add_req(REQ_ENCODE, 8'd3, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
		// A symbol that was never written has no entry and emits nothing.
		add_req(REQ_ENCODE, 8'd200, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
		add_req(REQ_ENCODE, 8'd0, 64'h0, 7'd0);
		add_req(REQ_ENCODE, 8'd2, 64'h0, 7'd0);
		add_req(REQ_ENCODE, 8'd0, 64'h0, 7'd0);
		add_req(REQ_FLUSH, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
		add_req(REQ_ENCODE, 8'd255, 64'h0, 7'd0);
		add_req(REQ_ENCODE, 8'd1, 64'h0, 7'd0);
		add_req(REQ_ENCODE, 8'd0, 64'h0, 7'd0);
		add_req(REQ_ENCODE, 8'd4, 64'h0, 7'd0);
		add_req(REQ_FLUSH, 8'h00, 64'h0, 7'd0);
		add_req(REQ_UNKNOWN, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
		add_req(REQ_WRITE, 8'd0, 64'h0, 7'd0);
		add_req(REQ_ENCODE, 8'd0, 64'h0, 7'd0);
		add_req(REQ_WRITE, 8'd5, 64'hFFFF_FFFF_FFFF_FFFF, 7'd8);
		add_req(REQ_ENCODE, 8'd5, 64'h0, 7'd0);
		add_req(REQ_FLUSH, 8'h00, 64'h0, 7'd0);
		for (k = 0; k < 6; k++) begin
			written[k] = 1'b1;
			wr_list = {wr_list, k[7:0]};
		end
		written[255] = 1'b1;
		wr_list = {wr_list, 8'd255};

		// Random traffic; encodes only touch entries that have been written.
		k = 0;
		while (k < RAND_ITEMS) begin
			tx_calm = ((k / 40) % 4 == 2);
			pick = $urandom_range(0, 99);
			sym = 8'($urandom_range(0, 255));
			bits = {$urandom, $urandom};
			len = 7'($urandom_range(0, 127));
			if (pick < 20) begin
				lsel = $urandom_range(0, 99);
				if (lsel < 60)
					len = 7'($urandom_range(1, 8));
				else if (lsel < 80)
					len = 7'($urandom_range(9, 24));
				else if (lsel < 90)
					len = 7'($urandom_range(25, 64));
				else if (lsel < 95)
					len = 7'($urandom_range(65, 127));
				else
					len = 7'd0;
				add_req(REQ_WRITE, sym, bits, len);
				if (!written[sym]) begin
					written[sym] = 1'b1;
					wr_list = {wr_list, sym};
				end
				k++;
			end else if (pick < 85) begin
				sym = wr_list[$urandom_range(0, wr_list.size() - 1)];
				add_req(REQ_ENCODE, sym, bits, len);
				k++;
			end else if (pick < 95) begin
				add_req(REQ_FLUSH, sym, bits, len);
				k++;
			end else begin
				add_req(REQ_UNKNOWN, sym, bits, len);
				k++;
			end
		end
		add_req(REQ_FLUSH, 8'h00, 64'h0, 7'd0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_backlog.size() != 0 || in_accepted != in_sent)
			@(posedge clk);
		while (coded_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (coded_bytes_due.size() != 0) begin
			$error("%0d expected bytes never arrived", coded_bytes_due.size());
			fails++;
		end
		if (fails == 0) begin
			$display("** prefix_code_bit_packer_unit: PASSED **");
		end else begin
			$display("** prefix_code_bit_packer_unit: FAILED **");
		end
		$finish;
	end

endmodule

[sim.f]
sv/pcbp_pkg.sv
sv/pcbp_code_table.sv
sv/prefix_code_bit_packer_unit.sv
sv/pcbp_checker.sv
tb/sv/tb_top.sv
